@@ src/upc_pkg.sv @@
package upc_pkg;

  localparam int unsigned DATA_W        = 32;
  localparam int unsigned FRAC_BITS_DEF = 16;
  localparam int unsigned DIFF_W        = DATA_W + 1;
  localparam int unsigned TIME_STEP_W   = 31;

  // stream payload widths
  localparam int unsigned IN_DATA_W  = 7 * DATA_W;
  localparam int unsigned IN_USER_W  = 2;
  localparam int unsigned OUT_DATA_W = 2 * DATA_W;
  localparam int unsigned OUT_USER_W = 1;

  // config port
  localparam int unsigned CFG_ADDR_W = 5;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned REG_IDX_W  = 3;

  localparam logic [REG_IDX_W-1:0] REG_LAMBDA      = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_TIME_STEP   = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_BND_AREA    = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_BND_DISCH   = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_BND_TIED    = 3'd4;

  localparam logic [DATA_W-1:0] SAT_MAX = 32'h7fff_ffff;
  localparam logic [DATA_W-1:0] SAT_MIN = 32'h8000_0000;

  // node held in the input register
  typedef struct packed {
    logic                     corr;
    logic                     first;
    logic signed [DATA_W-1:0] a_now;
    logic signed [DATA_W-1:0] q_now;
    logic signed [DATA_W-1:0] a_pred;
    logic signed [DATA_W-1:0] q_pred;
    logic signed [DIFF_W-1:0] d_mass;
    logic signed [DIFF_W-1:0] d_mom;
    logic signed [DATA_W-1:0] src;
  } upc_item_t;

  // register file contents other than the lambda ratio
  typedef struct packed {
    logic [TIME_STEP_W-1:0]   time_step;
    logic signed [DATA_W-1:0] bnd_area;
    logic signed [DATA_W-1:0] bnd_disch;
    logic                     bnd_tied;
  } upc_cfg_t;

endpackage

@@ src/upc_cfg_regs.sv @@
module upc_cfg_regs #(
  parameter int unsigned LAMBDA_W = upc_pkg::FRAC_BITS_DEF + 2
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [upc_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [upc_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [upc_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                             pready,
  output logic [LAMBDA_W-1:0]              lambda,
  output upc_pkg::upc_cfg_t                cfg
);
  import upc_pkg::*;

  logic [LAMBDA_W-1:0]    lambda_r;
  logic [TIME_STEP_W-1:0] time_step_r;
  logic [DATA_W-1:0]      bnd_area_r;
  logic [DATA_W-1:0]      bnd_disch_r;
  logic                   bnd_tied_r;
  logic                   wr_en;
  logic [REG_IDX_W-1:0]   idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign idx    = paddr[CFG_ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lambda_r    <= '0;
      time_step_r <= '0;
      bnd_area_r  <= '0;
      bnd_disch_r <= '0;
      bnd_tied_r  <= 1'b1;
    end else if (wr_en) begin
      case (idx)
        REG_LAMBDA:    lambda_r    <= pwdata[LAMBDA_W-1:0];
        REG_TIME_STEP: time_step_r <= pwdata[TIME_STEP_W-1:0];
        REG_BND_AREA:  bnd_area_r  <= pwdata[DATA_W-1:0];
        REG_BND_DISCH: bnd_disch_r <= pwdata[DATA_W-1:0];
        REG_BND_TIED:  bnd_tied_r  <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_LAMBDA:    prdata = CFG_DATA_W'(lambda_r);
      REG_TIME_STEP: prdata = CFG_DATA_W'(time_step_r);
      REG_BND_AREA:  prdata = bnd_area_r;
      REG_BND_DISCH: prdata = bnd_disch_r;
      REG_BND_TIED:  prdata = CFG_DATA_W'(bnd_tied_r);
      default:       prdata = '0;
    endcase
  end

  assign lambda        = lambda_r;
  assign cfg.time_step = time_step_r;
  assign cfg.bnd_area  = bnd_area_r;
  assign cfg.bnd_disch = bnd_disch_r;
  assign cfg.bnd_tied  = bnd_tied_r;

endmodule

@@ src/upc_in_stage.sv @@
module upc_in_stage (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [upc_pkg::IN_DATA_W-1:0]   in_data,
  input  logic [upc_pkg::IN_USER_W-1:0]   in_user,
  output logic                            s1_valid,
  input  logic                            s1_ready,
  output upc_pkg::upc_item_t              s1_item
);
  import upc_pkg::*;

  logic                     s1_valid_r;
  logic                     s1_valid_nxt;
  upc_item_t                item_r;
  upc_item_t                item_nxt;
  logic signed [DATA_W-1:0] last_mass_r;
  logic signed [DATA_W-1:0] last_mom_r;
  logic signed [DATA_W-1:0] f_mass;
  logic signed [DATA_W-1:0] f_mom;
  logic                     take;

  assign in_ready = !s1_valid_r || s1_ready;
  assign take     = in_valid && in_ready;

  assign f_mass = in_data[5*DATA_W-1:4*DATA_W];
  assign f_mom  = in_data[6*DATA_W-1:5*DATA_W];

  always_comb begin
    item_nxt.corr   = in_user[0];
    item_nxt.first  = in_user[1];
    item_nxt.a_now  = in_data[DATA_W-1:0];
    item_nxt.q_now  = in_data[2*DATA_W-1:DATA_W];
    item_nxt.a_pred = in_data[3*DATA_W-1:2*DATA_W];
    item_nxt.q_pred = in_data[4*DATA_W-1:3*DATA_W];
    item_nxt.src    = in_data[7*DATA_W-1:6*DATA_W];
    // backward flux difference; node zero sees no upstream flux
    if (in_user[1]) begin
      item_nxt.d_mass = DIFF_W'(f_mass);
      item_nxt.d_mom  = DIFF_W'(f_mom);
    end else begin
      item_nxt.d_mass = DIFF_W'(f_mass) - DIFF_W'(last_mass_r);
      item_nxt.d_mom  = DIFF_W'(f_mom) - DIFF_W'(last_mom_r);
    end
  end

  always_comb begin
    if (take) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_ready) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      last_mass_r <= '0;
      last_mom_r  <= '0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      if (take) begin
        last_mass_r <= f_mass;
        last_mom_r  <= f_mom;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item_r <= item_nxt;
    end
  end

  assign s1_valid = s1_valid_r;
  assign s1_item  = item_r;

endmodule

@@ src/upc_update.sv @@
module upc_update #(
  parameter int unsigned FRAC_BITS = upc_pkg::FRAC_BITS_DEF,
  parameter int unsigned LAMBDA_W  = FRAC_BITS + 2
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            s1_valid,
  output logic                            s1_ready,
  input  upc_pkg::upc_item_t              s1_item,
  input  logic [LAMBDA_W-1:0]             lambda,
  input  upc_pkg::upc_cfg_t               cfg,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [upc_pkg::OUT_DATA_W-1:0]  out_data,
  output logic [upc_pkg::OUT_USER_W-1:0]  out_user
);
  import upc_pkg::*;

  localparam int unsigned LDF_W = LAMBDA_W + 1 + DIFF_W;
  localparam int unsigned DTS_W = TIME_STEP_W + 1 + DATA_W;
  localparam int unsigned SUM_W = ((LDF_W > DTS_W) ? LDF_W : DTS_W) + 3;

  logic signed [LDF_W-1:0]  ldf_mass;
  logic signed [LDF_W-1:0]  ldf_mom;
  logic signed [DTS_W-1:0]  dts;
  logic signed [SUM_W-1:0]  a_sum;
  logic signed [SUM_W-1:0]  q_sum;
  logic signed [SUM_W-1:0]  a_fin;
  logic signed [SUM_W-1:0]  q_fin;
  logic                     a_ovf;
  logic                     q_ovf;
  logic [DATA_W-1:0]        a_res;
  logic [DATA_W-1:0]        q_res;
  logic                     sat;
  logic                     load;
  logic                     out_valid_r;
  logic                     out_valid_nxt;
  logic [OUT_DATA_W-1:0]    out_data_r;
  logic [OUT_USER_W-1:0]    out_user_r;

  assign s1_ready = !out_valid_r || out_ready;
  assign load     = s1_valid && s1_ready;

  // products floored back to the value format
  assign ldf_mass = ($signed({1'b0, lambda}) * s1_item.d_mass) >>> FRAC_BITS;
  assign ldf_mom  = ($signed({1'b0, lambda}) * s1_item.d_mom) >>> FRAC_BITS;
  assign dts      = ($signed({1'b0, cfg.time_step}) * s1_item.src) >>> FRAC_BITS;

  always_comb begin
    a_sum = SUM_W'(s1_item.a_now) - SUM_W'(ldf_mass);
    q_sum = SUM_W'(s1_item.q_now) - SUM_W'(ldf_mom) + SUM_W'(dts);
    if (s1_item.corr) begin
      a_fin = (a_sum + SUM_W'(s1_item.a_pred)) >>> 1;
      q_fin = (q_sum + SUM_W'(s1_item.q_pred)) >>> 1;
    end else begin
      a_fin = a_sum;
      q_fin = q_sum;
    end
  end

  assign a_ovf = !((&a_fin[SUM_W-1:DATA_W-1]) || !(|a_fin[SUM_W-1:DATA_W-1]));
  assign q_ovf = !((&q_fin[SUM_W-1:DATA_W-1]) || !(|q_fin[SUM_W-1:DATA_W-1]));

  always_comb begin
    if (s1_item.first && cfg.bnd_tied) begin
      a_res = cfg.bnd_area;
      q_res = cfg.bnd_disch;
      sat   = 1'b0;
    end else begin
      a_res = a_ovf ? (a_fin[SUM_W-1] ? SAT_MIN : SAT_MAX) : a_fin[DATA_W-1:0];
      q_res = q_ovf ? (q_fin[SUM_W-1] ? SAT_MIN : SAT_MAX) : q_fin[DATA_W-1:0];
      sat   = a_ovf || q_ovf;
    end
  end

  always_comb begin
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data_r <= {q_res, a_res};
      out_user_r <= sat;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_user  = out_user_r;

endmodule

@@ src/upwind_predictor_corrector_node.sv @@
// Channel   Direction  Width            Contents
// in_       slave      tdata 224, u 2   one grid node: state, prediction, fluxes, source
// out_      master     tdata 64,  u 1   updated area and discharge, clip flag
// cfg_      APB slave  addr 5, data 32  lambda, dt, boundary values, boundary tie
//
// One node per cycle sustained while out_tready is high. Two registers: the
// input register (flux difference formed on the way in) and the result register;
// the lambda*dF and dt*S multipliers plus the final add and clip sit between them.
// rst_n is synchronous, active low; it empties both stages, zeroes the stored
// fluxes and sets the registers to defaults (boundary tied).
// A stall on out_tready holds the result; the input register still takes one
// more node, then in_tready drops until the result is taken.
module upwind_predictor_corrector_node #(
  parameter int unsigned FRAC_BITS = upc_pkg::FRAC_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // node stream
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // [31:0] area_now, [63:32] discharge_now, [95:64] area_pred,
  // [127:96] discharge_pred, [159:128] flux_mass, [191:160] flux_momentum,
  // [223:192] source
  input  logic [upc_pkg::IN_DATA_W-1:0]   in_tdata,
  // [0] mode, [1] first_node
  input  logic [upc_pkg::IN_USER_W-1:0]   in_tuser,
  // result stream
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [31:0] area_out, [63:32] discharge_out
  output logic [upc_pkg::OUT_DATA_W-1:0]  out_tdata,
  // [0] saturated
  output logic [upc_pkg::OUT_USER_W-1:0]  out_tuser,
  // register port
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [upc_pkg::CFG_ADDR_W-1:0]  cfg_paddr,
  input  logic [upc_pkg::CFG_DATA_W-1:0]  cfg_pwdata,
  output logic [upc_pkg::CFG_DATA_W-1:0]  cfg_prdata,
  output logic                            cfg_pready
);
  import upc_pkg::*;

  // lambda is Q2.FRAC_BITS
  localparam int unsigned LAMBDA_W = FRAC_BITS + 2;

  logic [LAMBDA_W-1:0] lambda;
  upc_cfg_t            cfg;
  logic                s1_valid;
  logic                s1_ready;
  upc_item_t           s1_item;

  upc_cfg_regs #(
    .LAMBDA_W (LAMBDA_W)
  ) u_cfg_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .lambda  (lambda),
    .cfg     (cfg)
  );

  // input register plus the previous node's fluxes
  upc_in_stage u_in_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_data  (in_tdata),
    .in_user  (in_tuser),
    .s1_valid (s1_valid),
    .s1_ready (s1_ready),
    .s1_item  (s1_item)
  );

  // predictor / corrector update and result register
  upc_update #(
    .FRAC_BITS (FRAC_BITS),
    .LAMBDA_W  (LAMBDA_W)
  ) u_update (
    .clk       (clk),
    .rst_n     (rst_n),
    .s1_valid  (s1_valid),
    .s1_ready  (s1_ready),
    .s1_item   (s1_item),
    .lambda    (lambda),
    .cfg       (cfg),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_tdata),
    .out_user  (out_tuser)
  );

  // an empty result register must never block the input side
  a_no_block: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty result register");

  // a held node moves into a free result register at once
  a_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid && !out_tvalid) |=> out_tvalid)
    else $error("held node did not advance");

  // clip flag only with a value at a rail
  a_clip_rail: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[0]) |->
      (out_tdata[DATA_W-1:0] == SAT_MAX || out_tdata[DATA_W-1:0] == SAT_MIN ||
       out_tdata[OUT_DATA_W-1:DATA_W] == SAT_MAX ||
       out_tdata[OUT_DATA_W-1:DATA_W] == SAT_MIN))
    else $error("saturated flag without clipped value");

  // a result transaction frees a slot, so the input side is open that cycle
  a_ready_when_moving: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready) |-> in_tready)
    else $error("input stalled while result drains");

endmodule

@@ tb/sv/upwind_predictor_corrector_node_tb.sv @@
`timescale 1ns / 1ps

// Predictor vs corrector pass, carried in tuser bit 0.
typedef enum logic {
  PASS_PREDICT = 1'b0,
  PASS_CORRECT = 1'b1
} pass_e;

// One grid node as it crosses the in_ stream.
typedef struct packed {
  logic               corr;
  logic               first;
  logic signed [31:0] a_now;
  logic signed [31:0] q_now;
  logic signed [31:0] a_pred;
  logic signed [31:0] q_pred;
  logic signed [31:0] f_mass;
  logic signed [31:0] f_mom;
  logic signed [31:0] src;
} grid_node_t;

// Updated node as it leaves on the out_ stream.
typedef struct packed {
  logic signed [31:0] area;
  logic signed [31:0] disch;
  logic               sat;
} node_update_t;

// Mirrors the register file and the stored fluxes, predicts each node update
// and checks the block's results in order.
class node_update_tracker;
  longint       lambda_q;
  longint       dt_q;
  longint       bnd_area;
  longint       bnd_disch;
  bit           bnd_tied;
  longint       prev_mass;
  longint       prev_mom;
  node_update_t pending_updates[$];
  int           errors;

  function new();
    lambda_q  = 0;
    dt_q      = 0;
    bnd_area  = 0;
    bnd_disch = 0;
    bnd_tied  = 1'b1;
    prev_mass = 0;
    prev_mom  = 0;
    errors    = 0;
  endfunction

  function void set_register(logic [2:0] idx, logic [31:0] val);
    case (idx)
      upc_pkg::REG_LAMBDA:    lambda_q  = longint'({46'd0, val[17:0]});
      upc_pkg::REG_TIME_STEP: dt_q      = longint'({33'd0, val[30:0]});
      upc_pkg::REG_BND_AREA:  bnd_area  = longint'($signed(val));
      upc_pkg::REG_BND_DISCH: bnd_disch = longint'($signed(val));
      upc_pkg::REG_BND_TIED:  bnd_tied  = val[0];
      default: ;
    endcase
  endfunction

  function logic [31:0] clip32(longint v, inout bit clip);
    if (v > 64'sd2147483647) begin
      clip = 1'b1;
      return upc_pkg::SAT_MAX;
    end
    if (v < -64'sd2147483648) begin
      clip = 1'b1;
      return upc_pkg::SAT_MIN;
    end
    return v[31:0];
  endfunction

  // Products are exact in 64 bits; >>> floors them, as does the halving.
  function void note_node(grid_node_t n);
    longint       d_mass;
    longint       d_mom;
    longint       sum_a;
    longint       sum_q;
    bit           clip;
    node_update_t u;
    d_mass = longint'($signed(n.f_mass)) - (n.first ? 64'sd0 : prev_mass);
    d_mom  = longint'($signed(n.f_mom)) - (n.first ? 64'sd0 : prev_mom);
    sum_a  = longint'($signed(n.a_now))
             - ((lambda_q * d_mass) >>> upc_pkg::FRAC_BITS_DEF);
    sum_q  = longint'($signed(n.q_now))
             - ((lambda_q * d_mom) >>> upc_pkg::FRAC_BITS_DEF)
             + ((dt_q * longint'($signed(n.src))) >>> upc_pkg::FRAC_BITS_DEF);
    if (n.corr == PASS_CORRECT) begin
      sum_a = (sum_a + longint'($signed(n.a_pred))) >>> 1;
      sum_q = (sum_q + longint'($signed(n.q_pred))) >>> 1;
    end
    clip    = 1'b0;
    u.area  = clip32(sum_a, clip);
    u.disch = clip32(sum_q, clip);
    if (n.first && bnd_tied) begin
      u.area  = bnd_area[31:0];
      u.disch = bnd_disch[31:0];
      clip    = 1'b0;
    end
    u.sat     = clip;
    prev_mass = longint'($signed(n.f_mass));
    prev_mom  = longint'($signed(n.f_mom));
    pending_updates.push_back(u);
  endfunction

  function void check_update(logic [31:0] area, logic [31:0] disch, logic sat);
    node_update_t e;
    if (pending_updates.size() == 0) begin
      $error("unexpected result: area_out %0d discharge_out %0d saturated %0b",
             $signed(area), $signed(disch), sat);
      errors++;
      return;
    end
    e = pending_updates.pop_front();
    if (e.area !== area) begin
      $error("area_out: expected %0d, got %0d", e.area, $signed(area));
      errors++;
    end
    if (e.disch !== disch) begin
      $error("discharge_out: expected %0d, got %0d", e.disch, $signed(disch));
      errors++;
    end
    if (e.sat !== sat) begin
      $error("saturated: expected %0b, got %0b", e.sat, sat);
      errors++;
    end
  endfunction
endclass

module upwind_predictor_corrector_node_tb;

  // Generous bound for ~1000 nodes plus drains.
  localparam int unsigned CYCLE_LIMIT = 200000;

  localparam logic [31:0] W_MAX = 32'h7fff_ffff;
  localparam logic [31:0] W_MIN = 32'h8000_0000;
  localparam logic [31:0] W_ONE = 32'h0001_0000;  // 1.0 in Q16.16

  // Index past the register list; a write there must change nothing.
  localparam logic [upc_pkg::REG_IDX_W-1:0] REG_UNUSED = 3'd5;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                           in_tvalid = 1'b0;
  logic                           in_tready;
  // [31:0] area_now, [63:32] discharge_now, [95:64] area_pred,
  // [127:96] discharge_pred, [159:128] flux_mass, [191:160] flux_momentum,
  // [223:192] source
  logic [upc_pkg::IN_DATA_W-1:0]  in_tdata = '0;
  // [0] mode, [1] first_node
  logic [upc_pkg::IN_USER_W-1:0]  in_tuser = '0;

  logic                           out_tvalid;
  logic                           out_tready = 1'b0;
  // [31:0] area_out, [63:32] discharge_out
  logic [upc_pkg::OUT_DATA_W-1:0] out_tdata;
  // [0] saturated
  logic [upc_pkg::OUT_USER_W-1:0] out_tuser;

  logic                           cfg_psel    = 1'b0;
  logic                           cfg_penable = 1'b0;
  logic                           cfg_pwrite  = 1'b0;
  logic [upc_pkg::CFG_ADDR_W-1:0] cfg_paddr   = '0;
  logic [upc_pkg::CFG_DATA_W-1:0] cfg_pwdata  = '0;
  logic [upc_pkg::CFG_DATA_W-1:0] cfg_prdata;
  logic                           cfg_pready;

  // Idle odds in percent per cycle, set per phase.
  int snd_idle_pct = 0;
  int rcv_idle_pct = 0;

  node_update_tracker tracker = new();

  upwind_predictor_corrector_node #(
    .FRAC_BITS(upc_pkg::FRAC_BITS_DEF)
  ) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Receiver back-pressure: one decision per cycle, taken on the falling edge.
  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= rcv_idle_pct);
  end

  // Both streams are watched at the rising edge. Values read here are the
  // pre-edge ones, since the block's registers update in the NBA region.
  // A result can't come from a node taken at this same edge, so checking
  // before noting keeps the queue order right.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      tracker.check_update(out_tdata[31:0], out_tdata[63:32], out_tuser[0]);
    end
    if (rst_n && in_tvalid && in_tready) begin
      tracker.note_node({in_tuser[0], in_tuser[1], in_tdata[31:0], in_tdata[63:32],
                         in_tdata[95:64], in_tdata[127:96], in_tdata[159:128],
                         in_tdata[191:160], in_tdata[223:192]});
    end
  end

  // Hard stop if the block hangs.
  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("upwind_predictor_corrector_node_tb: done, errors");
    $finish;
  end

  // APB write: setup cycle, then access cycle; lands on the edge with pready.
  // Called at a falling edge, returns at one.
  task automatic wr_reg(input logic [upc_pkg::REG_IDX_W-1:0] idx, input logic [31:0] val);
    cfg_psel    = 1'b1;
    cfg_pwrite  = 1'b1;
    cfg_penable = 1'b0;
    cfg_paddr   = {idx, 2'b00};
    cfg_pwdata  = val;
    @(negedge clk);
    cfg_penable = 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    @(negedge clk);
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    tracker.set_register(idx, val);
  endtask

  // Offer one node; random idle cycles first. tvalid is written once per
  // falling edge, so back-to-back nodes keep it high without a glitch.
  task automatic send_node(input pass_e mode, input logic first,
                           input logic [31:0] a, input logic [31:0] q,
                           input logic [31:0] ap, input logic [31:0] qp,
                           input logic [31:0] fm, input logic [31:0] fq,
                           input logic [31:0] s);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser  = {first, mode};
    in_tdata  = {s, fq, fm, qp, ap, q, a};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // Wait for every outstanding update, then an idle margin past the
  // two-stage pipe before touching registers or ending.
  task automatic drain();
    in_tvalid = 1'b0;
    while (tracker.pending_updates.size() != 0) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  // Mix of rails, zero, full-range and modest magnitudes so that both the
  // clipped and the unclipped paths see plenty of traffic.
  function automatic logic [31:0] rand_word();
    case ($urandom_range(9))
      0:       return W_MAX;
      1:       return W_MIN;
      2:       return 32'd0;
      3, 4:    return $urandom;
      default: return $urandom_range(0, 32'h00ff_ffff) - 32'h0080_0000;
    endcase
  endfunction

  // Mostly well-formed passes over short grids (first_node on node zero, one
  // mode per pass); some passes lose their first flag, and one pick in ten
  // sends a lone node with random flags.
  task automatic run_random(input int n_items);
    int    sent;
    int    run_len;
    pass_e mode;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(9) == 0) begin
        send_node(pass_e'($urandom_range(1)), ($urandom_range(1) == 1),
                  rand_word(), rand_word(), rand_word(), rand_word(),
                  rand_word(), rand_word(), rand_word());
        sent++;
      end else begin
        run_len = $urandom_range(1, 12);
        mode    = pass_e'($urandom_range(1));
        for (int k = 0; k < run_len; k++) begin
          send_node(mode, (k == 0) && ($urandom_range(7) != 0),
                    rand_word(), rand_word(), rand_word(), rand_word(),
                    rand_word(), rand_word(), rand_word());
          sent++;
        end
      end
    end
  endtask

  initial begin
    snd_idle_pct = 20;
    rcv_idle_pct = 30;
    repeat (3) @(negedge clk);
    rst_n = 1'b1;

    // Directed, setting A: largest lambda and dt, boundary on the rails, tied.
    wr_reg(upc_pkg::REG_LAMBDA,    32'h0003_ffff);
    wr_reg(upc_pkg::REG_TIME_STEP, 32'h7fff_ffff);
    wr_reg(upc_pkg::REG_BND_AREA,  W_MIN);
    wr_reg(upc_pkg::REG_BND_DISCH, W_MAX);
    wr_reg(upc_pkg::REG_BND_TIED,  32'd1);
    // tied first node: boundary values win, flux state still loads
    send_node(PASS_PREDICT, 1'b1, W_MAX, W_MAX, 0, 0, W_MAX, W_MAX, W_MAX);
    // big negative dF -> clip high on both outputs
    send_node(PASS_PREDICT, 1'b0, W_MAX, W_MAX, 0, 0, W_MIN, W_MIN, W_MAX);
    // big positive dF, negative source -> clip low
    send_node(PASS_PREDICT, 1'b0, W_MIN, W_MIN, 0, 0, W_MAX, W_MAX, W_MIN);
    // corrector, zero dF: (max + max) >> 1 is exactly max, no clip
    send_node(PASS_CORRECT, 1'b0, W_MAX, W_MAX, W_MAX, W_MAX, W_MAX, W_MAX, 0);
    // corrector: area clips high, discharge clips low
    send_node(PASS_CORRECT, 1'b0, W_MIN, W_MIN, W_MIN, W_MIN, W_MIN, W_MIN, W_MIN);
    // tied first node in a corrector pass
    send_node(PASS_CORRECT, 1'b1, 0, 0, W_MAX, W_MIN, W_MIN, W_MAX, W_MAX);
    send_node(PASS_PREDICT, 1'b0, 0, 0, 0, 0, 0, 0, 0);
    drain();

    // Directed, setting B: untied, lambda 0.5 and dt 1.5 so products round.
    wr_reg(upc_pkg::REG_LAMBDA,    32'h0000_8000);
    wr_reg(upc_pkg::REG_TIME_STEP, 32'h0001_8000);
    wr_reg(upc_pkg::REG_BND_AREA,  32'h1234_5678);
    wr_reg(upc_pkg::REG_BND_DISCH, 32'hffff_ffff);
    wr_reg(upc_pkg::REG_BND_TIED,  32'd0);
    // untied first node: dF is the flux itself; odd negatives floor
    send_node(PASS_PREDICT, 1'b1, W_ONE, 2 * W_ONE, 0, 0,
              32'h0003_0001, 32'hffff_0001, 32'hffff_ffff);
    send_node(PASS_PREDICT, 1'b0, W_MIN, W_MAX, W_MAX, W_MIN,
              32'h0003_0000, 32'hffff_0001, 0);
    // corrector halving of -1 stays -1 (floor, not toward zero)
    send_node(PASS_CORRECT, 1'b0, 32'hffff_ffff, 32'hffff_ffff, 0, 0,
              32'h0003_0000, 32'hffff_0001, 0);
    send_node(PASS_CORRECT, 1'b1, 32'hffff_fffd, 32'hffff_fffb, 0, 1,
              1, 32'hffff_ffff, 32'hffff_ffff);
    send_node(PASS_CORRECT, 1'b0, W_MAX, W_MAX, W_MAX, W_MAX, W_MIN, W_MIN, W_MAX);
    send_node(PASS_PREDICT, 1'b0, W_MIN, W_MIN, W_MIN, W_MIN, W_MAX, W_MAX, W_MIN);
    drain();

    // Random phase 1: sender nearly always ready, receiver stalls a lot.
    wr_reg(upc_pkg::REG_LAMBDA,    $urandom_range(0, 32'h0003_ffff));
    wr_reg(upc_pkg::REG_TIME_STEP, $urandom_range(0, 32'h0010_0000));
    wr_reg(upc_pkg::REG_BND_AREA,  $urandom);
    wr_reg(upc_pkg::REG_BND_DISCH, $urandom);
    wr_reg(upc_pkg::REG_BND_TIED,  32'd1);
    snd_idle_pct = 6;
    rcv_idle_pct = 74;
    run_random(300);
    drain();

    // Random phase 2: lambda zero, dt at max; upper bits set on the writes
    // must be masked off (tied ends up 0).
    wr_reg(upc_pkg::REG_LAMBDA,    32'hfffc_0000);
    wr_reg(upc_pkg::REG_TIME_STEP, 32'hffff_ffff);
    wr_reg(upc_pkg::REG_BND_AREA,  $urandom);
    wr_reg(upc_pkg::REG_BND_DISCH, $urandom);
    wr_reg(upc_pkg::REG_BND_TIED,  32'hffff_fffe);
    snd_idle_pct = 74;
    rcv_idle_pct = 6;
    run_random(300);
    drain();

    // Random phase 3: no idling, lambda at max, tied again; a write past the
    // register list must leave everything alone.
    wr_reg(upc_pkg::REG_LAMBDA,    32'h0003_ffff);
    wr_reg(upc_pkg::REG_TIME_STEP, $urandom_range(0, 32'h0004_0000));
    wr_reg(upc_pkg::REG_BND_TIED,  32'd1);
    wr_reg(REG_UNUSED,             $urandom);
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    run_random(300);
    drain();

    if (tracker.errors == 0) begin
      $display("upwind_predictor_corrector_node_tb: done, clean");
    end else begin
      $display("upwind_predictor_corrector_node_tb: done, errors");
    end
    $finish;
  end

endmodule
